@@ sv/dft_pkg.sv @@
// ----------------------------------------------------------------------------
// dft_pkg
// Shared types, constants and helpers of the DShot frame transmitter.
// ----------------------------------------------------------------------------
package dft_pkg;

   localparam int COMMAND_DEPTH = 8;
   localparam int TIME_WIDTH    = 16;

   localparam int PTR_W = (COMMAND_DEPTH > 1) ? $clog2(COMMAND_DEPTH) : 1;
   localparam int CNT_W = $clog2(COMMAND_DEPTH + 1);

   localparam int VAL_W   = 11;
   localparam int TIME_W  = 16;
   localparam int FRAME_W = 16;
   localparam int BIDX_W  = 4;
   localparam int CSR_W   = 16;
   localparam int CIDX_W  = 3;

   localparam logic [BIDX_W-1:0] LAST_BIT    = 4'd15;
   localparam logic [3:0]        CSUM_MASK   = 4'hF;
   localparam logic [VAL_W-1:0]  CV_RESET    = 11'd48;

   // request selector codes
   localparam logic [1:0] FUNC_RAW      = 2'd0;
   localparam logic [1:0] FUNC_TELE     = 2'd1;
   localparam logic [1:0] FUNC_TICK     = 2'd2;
   localparam logic [1:0] FUNC_RESERVED = 2'd3;

   // register indexes
   localparam logic [CIDX_W-1:0] CSR_TELE_ALWAYS = 3'd0;
   localparam logic [CIDX_W-1:0] CSR_HIGH_ONE    = 3'd1;
   localparam logic [CIDX_W-1:0] CSR_LOW_ONE     = 3'd2;
   localparam logic [CIDX_W-1:0] CSR_HIGH_ZERO   = 3'd3;
   localparam logic [CIDX_W-1:0] CSR_LOW_ZERO    = 3'd4;
   localparam logic [CIDX_W-1:0] CSR_THR_FLOOR   = 3'd5;
   localparam logic [CIDX_W-1:0] CSR_THR_CEIL    = 3'd6;
   localparam logic [CIDX_W-1:0] CSR_CMD_FLOOR   = 3'd7;

   typedef struct packed {
      logic              telemetry_always;
      logic [TIME_W-1:0] high_time_one;
      logic [TIME_W-1:0] low_time_one;
      logic [TIME_W-1:0] high_time_zero;
      logic [TIME_W-1:0] low_time_zero;
      logic [VAL_W-1:0]  throttle_floor;
      logic [VAL_W-1:0]  throttle_ceiling;
      logic [VAL_W-1:0]  command_floor;
   } cfg_type;

   // one decoded request waiting for the pulse generator
   typedef struct packed {
      logic             is_frame;
      logic             accepted;
      logic             use_fifo;
      logic             use_slot;
      logic [VAL_W-1:0] slot_val;
      logic             tele;
   } job_type;

   function automatic logic [TIME_W-1:0] time_of(input logic [TIME_W-1:0] r);
      logic [TIME_W-1:0] m;
      logic [TIME_W-1:0] t;
      if (TIME_WIDTH >= TIME_W) begin
         m = '1;
      end else begin
         m = TIME_W'((64'd1 << TIME_WIDTH) - 64'd1);
      end
      t = r & m;
      return (t == '0) ? TIME_W'(1) : t;
   endfunction

   function automatic logic [FRAME_W-1:0] build_frame(input logic [VAL_W-1:0] cv,
                                                      input logic tele);
      logic [VAL_W:0] payload;
      logic [3:0]     csum;
      payload = {cv, tele};
      csum    = (payload[3:0] ^ payload[7:4] ^ payload[11:8]) & CSUM_MASK;
      return {payload, csum};
   endfunction

endpackage

@@ sv/dft_if.sv @@
// ----------------------------------------------------------------------------
// dft_if
// Request and response channel interfaces (valid/ready with payload).
// ----------------------------------------------------------------------------
interface dft_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [15:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

interface dft_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic        accepted;
   logic        bit_value;
   logic [15:0] high_time;
   logic [15:0] low_time;
   logic [15:0] frame_word;
   logic        last;

   modport source (output valid, output kind, output accepted, output bit_value,
                   output high_time, output low_time, output frame_word,
                   output last, input ready);
   modport sink   (input valid, input kind, input accepted, input bit_value,
                   input high_time, input low_time, input frame_word,
                   input last, output ready);
endinterface

@@ sv/dft_cmd_mem.sv @@
// ----------------------------------------------------------------------------
// dft_cmd_mem
// Command queue storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dft_cmd_mem (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [dft_pkg::PTR_W-1:0] wr_addr,
   input  logic [dft_pkg::VAL_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [dft_pkg::PTR_W-1:0] rd_addr,
   output logic [dft_pkg::VAL_W-1:0] rd_data
);
   import dft_pkg::*;

   logic [VAL_W-1:0] mem [COMMAND_DEPTH];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/dft_dispatch.sv @@
// ----------------------------------------------------------------------------
// dft_dispatch
// Request decode, throttle slot, queue pointers and telemetry flag.
// ----------------------------------------------------------------------------
module dft_dispatch (
   input  logic                      clock,
   input  logic                      reset,
   input  dft_pkg::cfg_type          cfg,
   dft_req_if.sink                   req,
   input  logic                      take,
   output logic                      job_valid,
   output dft_pkg::job_type          job,
   output logic                      wr_en,
   output logic [dft_pkg::PTR_W-1:0] wr_addr,
   output logic [dft_pkg::VAL_W-1:0] wr_data,
   output logic                      rd_en,
   output logic [dft_pkg::PTR_W-1:0] rd_addr
);
   import dft_pkg::*;

   logic             job_valid_ff, job_valid_in;
   job_type          job_ff, job_in;
   logic [VAL_W-1:0] slot_ff, slot_in;
   logic             slot_full_ff, slot_full_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             tele_once_ff, tele_once_in;
   logic             accept;
   logic             is_throttle;
   logic [VAL_W-1:0] clamped;

   function automatic logic [PTR_W-1:0] next_index(input logic [PTR_W-1:0] i);
      return (i == PTR_W'(COMMAND_DEPTH - 1)) ? '0 : PTR_W'(i + 1'b1);
   endfunction

   assign req.ready   = !job_valid_ff || take;
   assign accept      = req.valid && req.ready;
   assign is_throttle = req.value >= {5'd0, cfg.throttle_floor};
   assign clamped     = (req.value > {5'd0, cfg.throttle_ceiling}) ?
                        cfg.throttle_ceiling : req.value[VAL_W-1:0];

   always_comb begin
      job_valid_in = job_valid_ff;
      job_in       = job_ff;
      slot_in      = slot_ff;
      slot_full_in = slot_full_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      tele_once_in = tele_once_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      if (take) begin
         job_valid_in = 1'b0;
      end
      if (accept) begin
         job_valid_in    = 1'b1;
         job_in          = '0;
         case (req.func)
            FUNC_RAW: begin
               if (is_throttle) begin
                  slot_in         = clamped;
                  slot_full_in    = 1'b1;
                  job_in.accepted = 1'b1;
               end else if (req.value < {5'd0, cfg.command_floor} ||
                            count_ff >= CNT_W'(COMMAND_DEPTH)) begin
                  job_in.accepted = 1'b0;
               end else begin
                  wr_en           = 1'b1;
                  tail_in         = next_index(tail_ff);
                  count_in        = count_ff + 1'b1;
                  job_in.accepted = 1'b1;
               end
            end
            FUNC_TELE: begin
               tele_once_in    = 1'b1;
               job_in.accepted = 1'b1;
            end
            FUNC_TICK: begin
               job_in.is_frame = 1'b1;
               if (count_ff != '0) begin
                  rd_en           = 1'b1;
                  job_in.use_fifo = 1'b1;
                  head_in         = next_index(head_ff);
                  count_in        = count_ff - 1'b1;
               end else if (slot_full_ff) begin
                  job_in.use_slot = 1'b1;
                  job_in.slot_val = slot_ff;
                  slot_full_in    = 1'b0;
               end
               if (cfg.telemetry_always) begin
                  job_in.tele = 1'b1;
               end else if (tele_once_ff) begin
                  job_in.tele  = 1'b1;
                  tele_once_in = 1'b0;
               end
            end
            default: begin
               job_in.accepted = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         slot_ff      <= '0;
         slot_full_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         tele_once_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         slot_ff      <= slot_in;
         slot_full_ff <= slot_full_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         tele_once_ff <= tele_once_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;
   assign wr_addr   = tail_ff;
   assign wr_data   = req.value[VAL_W-1:0];
   assign rd_addr   = head_ff;

endmodule

@@ sv/dft_pulse_gen.sv @@
// ----------------------------------------------------------------------------
// dft_pulse_gen
// Frame assembly and serializer: status answers or sixteen bit pulses.
// ----------------------------------------------------------------------------
module dft_pulse_gen (
   input  logic                      clock,
   input  logic                      reset,
   input  dft_pkg::cfg_type          cfg,
   input  logic                      job_valid,
   input  dft_pkg::job_type          job,
   input  logic [dft_pkg::VAL_W-1:0] rd_data,
   output logic                      take,
   dft_rsp_if.source                 rsp
);
   import dft_pkg::*;

   logic               out_valid_ff, out_valid_in;
   logic               kind_ff, kind_in;
   logic               acc_ff, acc_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [BIDX_W-1:0]  idx_ff, idx_in;
   logic [VAL_W-1:0]   cv_ff, cv_in;
   logic               last_now;
   logic               out_free;
   logic               bit_now;
   logic [VAL_W-1:0]   cv_sel;

   assign last_now = !kind_ff || (idx_ff == LAST_BIT);
   assign out_free = !out_valid_ff || (rsp.ready && last_now);
   assign take     = job_valid && out_free;
   assign bit_now  = frame_ff[LAST_BIT - idx_ff];
   assign cv_sel   = job.use_fifo ? rd_data : (job.use_slot ? job.slot_val : cv_ff);

   always_comb begin
      out_valid_in = out_valid_ff;
      kind_in      = kind_ff;
      acc_in       = acc_ff;
      frame_in     = frame_ff;
      idx_in       = idx_ff;
      cv_in        = cv_ff;
      if (out_valid_ff && rsp.ready) begin
         if (last_now) begin
            out_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (take) begin
         out_valid_in = 1'b1;
         kind_in      = job.is_frame;
         acc_in       = job.accepted;
         idx_in       = '0;
         if (job.is_frame) begin
            cv_in    = cv_sel;
            frame_in = build_frame(cv_sel, job.tele);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         kind_ff      <= 1'b0;
         idx_ff       <= '0;
         cv_ff        <= CV_RESET;
      end else begin
         out_valid_ff <= out_valid_in;
         kind_ff      <= kind_in;
         idx_ff       <= idx_in;
         cv_ff        <= cv_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      frame_ff <= frame_in;
   end

   always_comb begin
      rsp.valid      = out_valid_ff;
      rsp.kind       = kind_ff;
      rsp.last       = last_now;
      rsp.accepted   = 1'b0;
      rsp.bit_value  = 1'b0;
      rsp.high_time  = '0;
      rsp.low_time   = '0;
      rsp.frame_word = '0;
      if (kind_ff) begin
         rsp.bit_value  = bit_now;
         rsp.frame_word = frame_ff;
         rsp.high_time  = bit_now ? time_of(cfg.high_time_one) : time_of(cfg.high_time_zero);
         rsp.low_time   = bit_now ? time_of(cfg.low_time_one) : time_of(cfg.low_time_zero);
      end else begin
         rsp.accepted = acc_ff;
      end
   end

endmodule

@@ sv/dshot_frame_transmitter.sv @@
// ----------------------------------------------------------------------------
// dshot_frame_transmitter
// DShot frame encoder: throttle slot, command queue, bit pulse serializer.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one request per handshake: func selects raw value,
//   telemetry once, frame tick or reserved; value is the raw throttle or
//   command. rsp_chan returns a single status answer (kind 0, last 1) for
//   every request but a frame tick, which returns sixteen bit pulses
//   (kind 1), MSB first, each with its high/low time and the whole frame,
//   last set on the sixteenth.
//   A request passes the holding register, then the output register.
//   Throughput, while rsp_chan.ready is high: one status request per cycle;
//   a frame tick holds the serializer for sixteen pulses, one per cycle.
//   The queue read is a registered memory port, issued at tick acceptance.
//   A decoded request waits in one holding register, so a new request is
//   taken while the current result is still being sent or stalled.
//   Stall: with rsp_chan.ready low the current result holds; once the
//   holding register is also full, req_chan.ready drops.
//   Reset: synchronous; control registers return to their defaults, queue and
//   throttle slot empty, current value 48. No memory clearing pass.
//   csr_* writes take effect at once and belong to idle periods.
// ----------------------------------------------------------------------------
module dshot_frame_transmitter (
   input  logic                       clock,
   input  logic                       reset,
   dft_req_if.sink                    req_chan,
   dft_rsp_if.source                  rsp_chan,
   input  logic                       csr_we,
   input  logic [dft_pkg::CIDX_W-1:0] csr_index,
   input  logic [dft_pkg::CSR_W-1:0]  csr_wdata
);
   import dft_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   job_type          job;
   logic             job_valid;
   logic             take;
   logic             wr_en;
   logic [PTR_W-1:0] wr_addr;
   logic [VAL_W-1:0] wr_data;
   logic             rd_en;
   logic [PTR_W-1:0] rd_addr;
   logic [VAL_W-1:0] rd_data;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TELE_ALWAYS: cfg_in.telemetry_always = csr_wdata[0];
            CSR_HIGH_ONE:    cfg_in.high_time_one    = csr_wdata;
            CSR_LOW_ONE:     cfg_in.low_time_one     = csr_wdata;
            CSR_HIGH_ZERO:   cfg_in.high_time_zero   = csr_wdata;
            CSR_LOW_ZERO:    cfg_in.low_time_zero    = csr_wdata;
            CSR_THR_FLOOR:   cfg_in.throttle_floor   = csr_wdata[VAL_W-1:0];
            CSR_THR_CEIL:    cfg_in.throttle_ceiling = csr_wdata[VAL_W-1:0];
            CSR_CMD_FLOOR:   cfg_in.command_floor    = csr_wdata[VAL_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.telemetry_always <= 1'b0;
         cfg_ff.high_time_one    <= TIME_W'(1);
         cfg_ff.low_time_one     <= TIME_W'(1);
         cfg_ff.high_time_zero   <= TIME_W'(1);
         cfg_ff.low_time_zero    <= TIME_W'(1);
         cfg_ff.throttle_floor   <= VAL_W'(48);
         cfg_ff.throttle_ceiling <= VAL_W'(2047);
         cfg_ff.command_floor    <= VAL_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // decode, slot and queue pointers
   dft_dispatch u_dispatch (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req       (req_chan),
      .take      (take),
      .job_valid (job_valid),
      .job       (job),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr)
   );

   // queued commands
   dft_cmd_mem u_cmd_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // frame build and output
   dft_pulse_gen u_pulse_gen (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (job_valid),
      .job       (job),
      .rd_data   (rd_data),
      .take      (take),
      .rsp       (rsp_chan)
   );

   // an accepted request always lands in the holding register
   a_accept_holds: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> job_valid)
      else $error("accepted request not held");

   // a status answer is a single result with no pulse fields
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.kind) |->
      (rsp_chan.last && rsp_chan.high_time == '0 && rsp_chan.frame_word == '0))
      else $error("malformed status answer");

   // pulses never carry a zero duration
   a_pulse_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.kind) |->
      (rsp_chan.high_time != '0 && rsp_chan.low_time != '0))
      else $error("zero pulse duration");

   // the final pulse carries the frame's LSB
   a_last_bit: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.kind && rsp_chan.last) |->
      (rsp_chan.bit_value == rsp_chan.frame_word[0]))
      else $error("last pulse bit mismatch");

endmodule
